### rtl/bcs_pkg.sv
// bcs_pkg: shared types and constants for the bilinear crop scaler.
// No dependencies; every rtl file imports it.
`default_nettype none

package bcs_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_CROP_TOP    = 3'd0;
	localparam logic [2:0] REG_CROP_BOTTOM = 3'd1;
	localparam logic [2:0] REG_CROP_LEFT   = 3'd2;
	localparam logic [2:0] REG_CROP_RIGHT  = 3'd3;
	localparam logic [2:0] REG_OUT_COLS    = 3'd4;
	localparam logic [2:0] REG_OUT_ROWS    = 3'd5;
	localparam logic [2:0] REG_BAND_SELECT = 3'd6;

	// input item function codes
	localparam logic FUNC_WRITE   = 1'b0;
	localparam logic FUNC_COMPUTE = 1'b1;

	// queue entry operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_BLEND = 2'd1;
	localparam logic [1:0] OP_ERR   = 2'd2;

	localparam int COORD_W  = 12;
	localparam int SPAN_W   = 9;
	localparam int NUM_W    = COORD_W + SPAN_W;
	localparam int SIZE_W   = 13;
	localparam int DIV_STEP = 8;
	localparam int QDEPTH   = 4;

	localparam logic [1:0] K_FIRST = 2'd0;
	localparam logic [1:0] K_LAST  = 2'd3;

	typedef struct packed {
		logic [7:0]  crop_top;
		logic [8:0]  crop_bottom;
		logic [7:0]  crop_left;
		logic [8:0]  crop_right;
		logic [12:0] out_cols;
		logic [12:0] out_rows;
		logic [5:0]  band_select;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/bcs_queue.sv
// bcs_queue: short FIFO of decoded operations between front and back.
// Depends on bcs_pkg for its depth.
`default_nettype none

module bcs_queue import bcs_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output logic [W-1:0]      head
);

	localparam int PW = $clog2(QDEPTH);

	logic [W-1:0]  slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign full       = (count_q == (PW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/bcs_front.sv
// bcs_front: accepts input beats, drops bad writes, maps compute items into the
// crop window (iterative divider) and builds blend weights. Depends on bcs_pkg.
`default_nettype none

module bcs_front import bcs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int NUM_BANDS  = 4,
	parameter int FRAC_BITS  = 8,
	parameter int EW         = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic [1:0]         band,
	input  wire logic [7:0]         pixel_in,
	output logic                    q_push,
	output logic [EW-1:0]           q_data,
	input  wire logic               q_full
);

	localparam int RW       = $clog2(MAX_HEIGHT);
	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int QW       = ((NUM_W + FRAC_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
	localparam int DIV_ITER = QW / DIV_STEP;
	localparam int ITW      = $clog2(DIV_ITER);
	localparam int AW       = QW - FRAC_BITS + 1;
	localparam int WW       = 2 * FRAC_BITS + 1;
	localparam logic [AW-1:0] LIM_Y = AW'(MAX_HEIGHT - 1);
	localparam logic [AW-1:0] LIM_X = AW'(MAX_WIDTH - 1);
	localparam logic [ITW-1:0] IT_LAST = ITW'(DIV_ITER - 1);

	localparam logic [1:0] FS_IDLE = 2'd0;
	localparam logic [1:0] FS_DIV  = 2'd1;
	localparam logic [1:0] FS_WGT  = 2'd2;
	localparam logic [1:0] FS_PUSH = 2'd3;

	logic               inq_vld_q, inq_func_q;
	logic [COORD_W-1:0] inq_row_q, inq_col_q;
	logic [1:0]         inq_band_q;
	logic [7:0]         inq_pix_q;

	logic [1:0]        fs_q;
	logic [ITW-1:0]    it_q;
	logic [QW-1:0]     dq_q  [2];
	logic [SIZE_W-1:0] rem_q [2];
	logic [EW-1:0]     ent_q;

	logic [SPAN_W-1:0] span [2];
	logic [NUM_W-1:0]  prod [2];
	logic [QW-1:0]     dq_nx  [2];
	logic [SIZE_W-1:0] rem_nx [2];
	logic [AW-1:0]     lo [2];
	logic [AW-1:0]     hi [2];
	logic [FRAC_BITS-1:0] frac [2];
	logic [SIZE_W-1:0] size [2];
	logic [7:0]        start [2];
	logic [8:0]        stop [2];
	logic [AW-1:0]     lim [2];
	logic [WW-1:0]     w00, w01, w10, w11;
	logic              oob, wr_ok, take, push_direct;
	logic [EW-1:0]     ent_direct;

	assign start[0] = cfg.crop_top;
	assign stop[0]  = cfg.crop_bottom;
	assign size[0]  = cfg.out_rows;
	assign lim[0]   = LIM_Y;
	assign start[1] = cfg.crop_left;
	assign stop[1]  = cfg.crop_right;
	assign size[1]  = cfg.out_cols;
	assign lim[1]   = LIM_X;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			span[a] = (stop[a] > {1'b0, start[a]}) ? stop[a] - {1'b0, start[a]} : '0;
		end
		prod[0] = NUM_W'(inq_row_q) * NUM_W'(span[0]);
		prod[1] = NUM_W'(inq_col_q) * NUM_W'(span[1]);
	end

	// radix-2 restoring division, DIV_STEP bits per cycle
	always_comb begin
		logic [SIZE_W:0]   t;
		logic [SIZE_W-1:0] r;
		logic [QW-1:0]     d;
		for (int a = 0; a < 2; a++) begin
			r = rem_q[a];
			d = dq_q[a];
			for (int s = 0; s < DIV_STEP; s++) begin
				t = {r, d[QW-1]};
				d = {d[QW-2:0], 1'b0};
				if (t >= {1'b0, size[a]}) begin
					t    = t - {1'b0, size[a]};
					d[0] = 1'b1;
				end
				r = t[SIZE_W-1:0];
			end
			dq_nx[a]  = d;
			rem_nx[a] = r;
		end
	end

	// base and next neighbor, clamped to the window's last index
	always_comb begin
		logic [AW-1:0] last, base;
		for (int a = 0; a < 2; a++) begin
			last = (stop[a] > {1'b0, start[a]}) ? AW'(stop[a] - 9'd1) : AW'(start[a]);
			if (last > lim[a]) last = lim[a];
			base = AW'(start[a]) + AW'(dq_q[a][QW-1:FRAC_BITS]);
			if (base > last) base = last;
			lo[a]   = base;
			hi[a]   = (base + 1'b1 > last) ? last : base + 1'b1;
			frac[a] = dq_q[a][FRAC_BITS-1:0];
		end
	end

	always_comb begin
		logic [FRAC_BITS:0] sx, sy, fx, fy;
		fx  = {1'b0, frac[1]};
		fy  = {1'b0, frac[0]};
		sx  = {1'b1, {FRAC_BITS{1'b0}}} - fx;
		sy  = {1'b1, {FRAC_BITS{1'b0}}} - fy;
		w00 = WW'(sx * sy);
		w01 = WW'(fx * sy);
		w10 = WW'(sx * fy);
		w11 = WW'(fx * fy);
	end

	assign oob   = ({1'b0, inq_row_q} >= cfg.out_rows) ||
	               ({1'b0, inq_col_q} >= cfg.out_cols);
	assign wr_ok = ({1'b0, inq_row_q} < SIZE_W'(MAX_HEIGHT)) &&
	               ({1'b0, inq_col_q} < SIZE_W'(MAX_WIDTH)) &&
	               ({1'b0, inq_band_q} < 3'(NUM_BANDS));

	always_comb begin
		take = 1'b0;
		if (inq_vld_q && fs_q == FS_IDLE) begin
			if (inq_func_q == FUNC_WRITE) take = !wr_ok || !q_full;
			else                          take = !oob || !q_full;
		end
	end

	assign push_direct = take && (inq_func_q == FUNC_WRITE ? wr_ok : oob);
	assign ent_direct  = {(inq_func_q == FUNC_WRITE) ? OP_WRITE : OP_ERR,
	                      inq_band_q, inq_pix_q, inq_row_q[RW-1:0], RW'(0),
	                      inq_col_q[CW-1:0], CW'(0), (4*WW)'(0)};
	assign q_push   = push_direct || (fs_q == FS_PUSH && !q_full);
	assign q_data   = (fs_q == FS_PUSH) ? ent_q : ent_direct;
	assign in_ready = !inq_vld_q || take;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			inq_func_q <= func;
			inq_row_q  <= row;
			inq_col_q  <= col;
			inq_band_q <= band;
			inq_pix_q  <= pixel_in;
		end
		for (int a = 0; a < 2; a++) begin
			if (take && inq_func_q == FUNC_COMPUTE && !oob) begin
				dq_q[a]  <= QW'({prod[a], {FRAC_BITS{1'b0}}});
				rem_q[a] <= '0;
			end else if (fs_q == FS_DIV) begin
				dq_q[a]  <= dq_nx[a];
				rem_q[a] <= rem_nx[a];
			end
		end
		if (fs_q == FS_WGT) begin
			ent_q <= {OP_BLEND, 2'd0, 8'd0, lo[0][RW-1:0], hi[0][RW-1:0],
			          lo[1][CW-1:0], hi[1][CW-1:0], w00, w01, w10, w11};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inq_vld_q <= 1'b0;
			fs_q      <= FS_IDLE;
			it_q      <= '0;
		end else begin
			if (in_ready) inq_vld_q <= in_valid;
			case (fs_q)
				FS_IDLE: begin
					it_q <= '0;
					if (take && inq_func_q == FUNC_COMPUTE && !oob) fs_q <= FS_DIV;
				end
				FS_DIV: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_LAST) fs_q <= FS_WGT;
				end
				FS_WGT: fs_q <= FS_PUSH;
				FS_PUSH: begin
					if (!q_full) fs_q <= FS_IDLE;
				end
				default: fs_q <= FS_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/bcs_back.sv
// bcs_back: executes queued operations against the banked frame store and
// accumulates the bilinear blend into the output register. Depends on bcs_pkg.
`default_nettype none

module bcs_back import bcs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int NUM_BANDS  = 4,
	parameter int FRAC_BITS  = 8,
	parameter int EW         = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [5:0]    band_select,
	input  wire logic          q_valid,
	input  wire logic [EW-1:0] q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         chan0,
	output logic [7:0]         chan1,
	output logic [7:0]         chan2,
	output logic               status
);

	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = 2 * FRAC_BITS + 1;
	localparam int ACW = WW + 8;
	localparam int DEPTH = 1 << (RW + CW);

	logic [1:0]    op, h_band;
	logic [7:0]    h_pix;
	logic [RW-1:0] r0, r1, ra_r;
	logic [CW-1:0] c0, c1, ra_c;
	logic [WW-1:0] w0, w1, w2, w3, wk;

	logic [1:0]     k_q, k_s1;
	logic           vld_s1, err_s1;
	logic [WW-1:0]  w_s1;
	logic [7:0]     rdat_s1 [NUM_BANDS];
	logic [ACW-1:0] acc_q [3];
	logic [ACW-1:0] sum [3];
	logic           out_valid_q, status_q;
	logic [7:0]     chan_q [3];

	logic stall, issue, rd_en, wr_en, fire;

	assign {op, h_band, h_pix, r0, r1, c0, c1, w0, w1, w2, w3} = q_head;

	// hold the whole pipe while the final beat of a blend or an error result waits for the output
	assign stall = vld_s1 && k_s1 == K_LAST && out_valid_q && !out_ready;
	assign issue = q_valid && !stall;
	assign rd_en = issue && op == OP_BLEND;
	assign wr_en = issue && op == OP_WRITE;
	assign q_pop = issue && (op != OP_BLEND || k_q == K_LAST);
	assign fire  = vld_s1 && !stall;

	always_comb begin
		case (k_q)
			2'd0: begin ra_r = r0; ra_c = c0; wk = w0; end
			2'd1: begin ra_r = r0; ra_c = c1; wk = w1; end
			2'd2: begin ra_r = r1; ra_c = c0; wk = w2; end
			default: begin ra_r = r1; ra_c = c1; wk = w3; end
		endcase
	end

	for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
		logic [7:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (wr_en && h_band == 2'(b)) mem[{r0, c0}] <= h_pix;
			if (rd_en) rdat_s1[b] <= mem[{ra_r, ra_c}];
		end
	end

	always_comb begin
		logic [1:0] sel;
		logic [7:0] p;
		for (int ch = 0; ch < 3; ch++) begin
			sel = band_select[2*ch +: 2];
			p   = '0;
			for (int b = 0; b < NUM_BANDS; b++) begin
				if (sel == 2'(b)) p = rdat_s1[b];
			end
			sum[ch] = ACW'(p * w_s1) + ((k_s1 == K_FIRST) ? '0 : acc_q[ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			w_s1 <= wk;
		end
		if (fire) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= sum[ch];
				if (k_s1 == K_LAST) chan_q[ch] <= err_s1 ? 8'd0 : sum[ch][2*FRAC_BITS +: 8];
			end
			if (k_s1 == K_LAST) status_q <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= K_FIRST;
			k_s1        <= K_FIRST;
			vld_s1      <= 1'b0;
			err_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) k_q <= k_q + 1'b1;
			if (!stall) begin
				vld_s1 <= issue && op != OP_WRITE;
				err_s1 <= op == OP_ERR;
				k_s1   <= (op == OP_BLEND) ? k_q : K_LAST;
			end
			if (fire && k_s1 == K_LAST) out_valid_q <= 1'b1;
			else if (out_ready)         out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign chan0     = chan_q[0];
	assign chan1     = chan_q[1];
	assign chan2     = chan_q[2];
	assign status    = status_q;

`ifndef SYNTHESIS
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && err_s1 |-> k_s1 == K_LAST)
		else $error("error slot not marked final");
	a_mid_blend_head: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != K_FIRST |-> q_valid && op == OP_BLEND)
		else $error("blend head left queue mid-sequence");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s1) && $past(k_s1) == K_LAST)
		else $error("result appeared without final beat");
`endif

endmodule

`default_nettype wire

### rtl/bilinear_crop_scaler_core.sv
// bilinear_crop_scaler_core: top level; config registers, front, queue, back.
// Depends on bcs_pkg, bcs_front, bcs_queue, bcs_back.
//
// channel | handshake           | payload
// cfg     | cfg_we              | cfg_index, cfg_data
// in      | in_valid / in_ready | func, row, col, band, pixel_in
// out     | out_valid/out_ready | chan0, chan1, chan2, status
//
// A write beat is checked and pushed directly or dropped; a compute beat holds the front
// through classification, four window mapping divider steps (8 quotient bits per
// cycle), the weights and a push into the queue, which waits while the queue is full.
// The back does four frame store reads per blend, one per neighbor,
// all bands in parallel. The queue lets the front run ahead of a stalled output.
// Reset clears control only; the frame store is undefined until written.
`default_nettype none

module bilinear_crop_scaler_core import bcs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int NUM_BANDS  = 4,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [12:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic [1:0]         band,
	input  wire logic [7:0]         pixel_in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              chan0,
	output logic [7:0]              chan1,
	output logic [7:0]              chan2,
	output logic                    status
);

	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = 2 * FRAC_BITS + 1;
	localparam int EW = 2 + 2 + 8 + 2 * RW + 2 * CW + 4 * WW;

	cfg_t          cfg_q;
	logic          q_push, q_full, q_pop, q_valid;
	logic [EW-1:0] q_data, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crop_top    <= 8'd0;
			cfg_q.crop_bottom <= 9'd256;
			cfg_q.crop_left   <= 8'd0;
			cfg_q.crop_right  <= 9'd256;
			cfg_q.out_cols    <= 13'd256;
			cfg_q.out_rows    <= 13'd256;
			cfg_q.band_select <= 6'd36;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CROP_TOP:    cfg_q.crop_top    <= cfg_data[7:0];
				REG_CROP_BOTTOM: cfg_q.crop_bottom <= cfg_data[8:0];
				REG_CROP_LEFT:   cfg_q.crop_left   <= cfg_data[7:0];
				REG_CROP_RIGHT:  cfg_q.crop_right  <= cfg_data[8:0];
				REG_OUT_COLS:    cfg_q.out_cols    <= cfg_data;
				REG_OUT_ROWS:    cfg_q.out_rows    <= cfg_data;
				REG_BAND_SELECT: cfg_q.band_select <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	bcs_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.NUM_BANDS(NUM_BANDS), .FRAC_BITS(FRAC_BITS), .EW(EW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .row(row), .col(col), .band(band), .pixel_in(pixel_in),
		.q_push(q_push), .q_data(q_data), .q_full(q_full)
	);

	bcs_queue #(.W(EW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_data), .full(q_full),
		.pop(q_pop), .head_valid(q_valid), .head(q_head)
	);

	bcs_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.NUM_BANDS(NUM_BANDS), .FRAC_BITS(FRAC_BITS), .EW(EW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .band_select(cfg_q.band_select),
		.q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.chan0(chan0), .chan1(chan1), .chan2(chan2), .status(status)
	);

endmodule

`default_nettype wire

### bench/tb_bilinear_crop_scaler_core.sv
// Self-checking bench for bilinear_crop_scaler_core: pixel writes and bilinear computes
// over many crop and size settings, with random idling on both channels.
// Depends on rtl/bcs_pkg.sv and rtl/bilinear_crop_scaler_core.sv.
`timescale 1ns / 100ps

module tb_bilinear_crop_scaler_core;
	import bcs_pkg::*;

	localparam int STORE_W = 256;
	localparam int STORE_H = 256;
	localparam int FRACB   = 8;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic       status;
	} pixel_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_CROP_TOP;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = FUNC_WRITE;
	logic [11:0] row = '0;
	logic [11:0] col = '0;
	logic [1:0]  band = '0;
	logic [7:0]  pixel_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  chan0, chan1, chan2;
	logic        status;

	bilinear_crop_scaler_core i_dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [7:0]  pixel_store [4*STORE_H*STORE_W];
	bit          written_mask [4*STORE_H*STORE_W];
	int unsigned crop_top_m = 0, crop_bottom_m = 256, crop_left_m = 0, crop_right_m = 256;
	int unsigned width_m = 256, height_m = 256, band_sel_m = 36;

	pixel_result_t pending_pixels[$];
	int errors = 0;
	int items_sent = 0;
	int computes_seen = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;

	task automatic map_pos(input int unsigned coord, start, stop, size, limit,
			output int unsigned lo, hi, frac);
		int unsigned span, last, num, base;
		longint unsigned rem;
		span = (stop > start) ? stop - start : 0;
		last = (stop > start) ? stop - 1 : start;
		num  = coord * span;
		base = start + num / size;
		rem  = num % size;
		if (last > limit - 1) last = limit - 1;
		if (base > last) base = last;
		lo = base;
		hi = (base + 1 > last) ? last : base + 1;
		frac = 32'((rem << FRACB) / size);
	endtask

	function automatic int unsigned store_addr(int unsigned b, r, c);
		return (b * STORE_H + r) * STORE_W + c;
	endfunction

	task automatic predict_pixel(input logic [11:0] r, c, output pixel_result_t res);
		int unsigned ylo, yhi, fy, xlo, xhi, fx, b;
		longint unsigned s, acc;
		logic [7:0] v [3];
		s = 64'd1 << FRACB;
		if (r >= height_m || c >= width_m) begin
			res = '{8'd0, 8'd0, 8'd0, 1'b1};
			return;
		end
		map_pos(r, crop_top_m, crop_bottom_m, height_m, STORE_H, ylo, yhi, fy);
		map_pos(c, crop_left_m, crop_right_m, width_m, STORE_W, xlo, xhi, fx);
		for (int k = 0; k < 3; k++) begin
			b = (band_sel_m >> (2 * k)) & 3;
			acc = pixel_store[store_addr(b, ylo, xlo)] * (s - fx) * (s - fy)
				+ pixel_store[store_addr(b, ylo, xhi)] * fx * (s - fy)
				+ pixel_store[store_addr(b, yhi, xlo)] * (s - fx) * fy
				+ pixel_store[store_addr(b, yhi, xhi)] * fx * fy;
			v[k] = 8'((acc >> (2 * FRACB)) & 255);
		end
		res = '{v[0], v[1], v[2], 1'b0};
	endtask

	// send one input beat; the predictor is updated at the accepting edge
	task automatic send_beat(input logic f, input logic [11:0] r, c,
			input logic [1:0] b, input logic [7:0] p);
		bit rdy;
		pixel_result_t res;
		if (!calm && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row <= r;
		col <= c;
		band <= b;
		pixel_in <= p;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		items_sent++;
		if (f == FUNC_WRITE) begin
			if (r < STORE_H && c < STORE_W) begin
				pixel_store[store_addr(b, r, c)] = p;
				written_mask[store_addr(b, r, c)] = 1'b1;
			end
		end else begin
			predict_pixel(r, c, res);
			pending_pixels.insert(pending_pixels.size(), res);
		end
	endtask

	// make sure every neighbor the compute reads holds a written value
	task automatic send_compute(input logic [11:0] r, c);
		int unsigned ylo, yhi, fy, xlo, xhi, fx, b, rr, cc;
		if (r < height_m && c < width_m) begin
			map_pos(r, crop_top_m, crop_bottom_m, height_m, STORE_H, ylo, yhi, fy);
			map_pos(c, crop_left_m, crop_right_m, width_m, STORE_W, xlo, xhi, fx);
			for (int k = 0; k < 3; k++) begin
				b = (band_sel_m >> (2 * k)) & 3;
				for (int q = 0; q < 4; q++) begin
					rr = q[1] ? yhi : ylo;
					cc = q[0] ? xhi : xlo;
					if (!written_mask[store_addr(b, rr, cc)])
						send_beat(FUNC_WRITE, 12'(rr), 12'(cc), 2'(b), 8'($urandom));
				end
			end
		end
		send_beat(FUNC_COMPUTE, r, c, 2'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		// a trailing write beat may still be in the pipe
		repeat (20) @(posedge clk);
	endtask

	// drive one register write; the caller drops cfg_we after the last one
	task automatic set_reg(input logic [2:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 13'(val);
		@(posedge clk);
		case (idx)
			REG_CROP_TOP:    crop_top_m = val & 8'hff;
			REG_CROP_BOTTOM: crop_bottom_m = val & 9'h1ff;
			REG_CROP_LEFT:   crop_left_m = val & 8'hff;
			REG_CROP_RIGHT:  crop_right_m = val & 9'h1ff;
			REG_OUT_COLS:    width_m = val & 13'h1fff;
			REG_OUT_ROWS:    height_m = val & 13'h1fff;
			default:         band_sel_m = val & 6'h3f;
		endcase
	endtask

	task automatic configure(input int unsigned t, bt, l, rt, w, h, bs);
		drain();
		set_reg(REG_CROP_TOP, t);
		set_reg(REG_CROP_BOTTOM, bt);
		set_reg(REG_CROP_LEFT, l);
		set_reg(REG_CROP_RIGHT, rt);
		set_reg(REG_OUT_COLS, w);
		set_reg(REG_OUT_ROWS, h);
		set_reg(REG_BAND_SELECT, bs);
		cfg_we <= 1'b0;
	endtask

	task automatic random_coord_compute();
		logic [11:0] r, c;
		if ($urandom_range(9) == 0) begin
			r = 12'($urandom);
			c = 12'($urandom);
		end else begin
			r = 12'($urandom_range(height_m - 1));
			c = 12'($urandom_range(width_m - 1));
		end
		send_compute(r, c);
	endtask

	task automatic test_default_extremes();
		send_beat(FUNC_WRITE, 12'd0, 12'd0, 2'd0, 8'd255);
		send_beat(FUNC_WRITE, 12'd255, 12'd255, 2'd3, 8'd0);
		send_beat(FUNC_WRITE, 12'd4095, 12'd3, 2'd1, 8'd77);   // row beyond store: dropped
		send_beat(FUNC_WRITE, 12'd3, 12'd300, 2'd2, 8'd99);    // col beyond store: dropped
		send_compute(12'd0, 12'd0);
		send_compute(12'd255, 12'd255);
		send_compute(12'd128, 12'd77);
		send_compute(12'd256, 12'd0);
		send_compute(12'd0, 12'd4095);
		send_compute(12'd4095, 12'd4095);
	endtask

	task automatic test_window_edges();
		// single-pixel window in the last store corner, huge output
		configure(255, 256, 255, 256, 4096, 4096, 0);
		send_compute(12'd4095, 12'd4095);
		send_compute(12'd0, 12'd2048);
		// empty window on both axes, all bands as band 3
		configure(200, 10, 180, 0, 1, 1, 63);
		send_compute(12'd0, 12'd0);
		send_compute(12'd1, 12'd0);
		// upscale a tiny window, fractions everywhere
		configure(10, 12, 20, 23, 13, 7, 27);
		for (int i = 0; i < 8; i++) random_coord_compute();
		// downscale whole store
		configure(0, 256, 0, 256, 3, 5, 36);
		for (int i = 0; i < 5; i++) random_coord_compute();
	endtask

	task automatic test_random_phases();
		int unsigned t, l, w, h;
		int phase;
		phase = 0;
		while (items_sent < 1150) begin
			t = $urandom_range(255);
			l = $urandom_range(255);
			w = ($urandom_range(3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 24);
			h = ($urandom_range(3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 24);
			configure(t, ($urandom_range(7) == 0) ? $urandom_range(1, 256)
					: ((t + $urandom_range(1, 6) > 256) ? 256 : t + $urandom_range(1, 6)),
				l, ($urandom_range(7) == 0) ? $urandom_range(1, 256)
					: ((l + $urandom_range(1, 6) > 256) ? 256 : l + $urandom_range(1, 6)),
				w, h, $urandom_range(63));
			calm = (phase == 8 || phase == 9);
			for (int i = 0; i < 25 && items_sent < 1150; i++) begin
				if ($urandom_range(4) == 0)
					send_beat(FUNC_WRITE, ($urandom_range(7) == 0) ? 12'($urandom)
						: 12'($urandom_range(255)), ($urandom_range(7) == 0) ? 12'($urandom)
						: 12'($urandom_range(255)), 2'($urandom), 8'($urandom));
				else
					random_coord_compute();
			end
			calm = 1'b0;
			phase++;
		end
	endtask

	// output channel: accept at random, with a calm stretch
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 25);

	always begin
		bit got;
		pixel_result_t act, exp_res;
		@(negedge clk);
		got = (out_valid === 1'b1) && out_ready;
		act = '{chan0, chan1, chan2, status};
		@(posedge clk);
		if (got) begin
			if (pending_pixels.size() == 0) begin
				$error("result beat with no compute outstanding");
				errors++;
			end else begin
				exp_res = pending_pixels.pop_front();
				computes_seen++;
				if (act.status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, act.status);
					errors++;
				end
				if (act.chan0 !== exp_res.chan0) begin
					$error("chan0: expected %0d, got %0d", exp_res.chan0, act.chan0);
					errors++;
				end
				if (act.chan1 !== exp_res.chan1) begin
					$error("chan1: expected %0d, got %0d", exp_res.chan1, act.chan1);
					errors++;
				end
				if (act.chan2 !== exp_res.chan2) begin
					$error("chan2: expected %0d, got %0d", exp_res.chan2, act.chan2);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("tb_bilinear_crop_scaler_core: errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_extremes();
		test_window_edges();
		test_random_phases();
		drain();
		$display("covered %0d input beats and %0d result beats over varied crop windows,",
			items_sent, computes_seen);
		$display("result sizes and band selections, including out-of-range coordinates");
		if (errors == 0)
			$display("tb_bilinear_crop_scaler_core: clean");
		else
			$display("tb_bilinear_crop_scaler_core: errors");
		$finish;
	end

endmodule
